// ===== rtl/omt_pkg.sv =====
`default_nettype none
package omt_pkg;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned SLOT_ID_W  = 6;
  localparam int unsigned CALLER_W   = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned GRANTED_W  = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ACQUIRE = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_OWNER   = 3'd2,
    ST_BUSY    = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/owned_mutex_table.sv =====
// Channel  Direction  Fields (tdata, lowest bit first)
// in_      slave      opcode[1:0], slot_id[7:2], caller[23:8]
// out_     master     status[2:0], granted_slot[8:3], zero pad[15:9]
//
// Each request is first captured, which reads the creator and holder memories; it is
// then checked for ownership, written back and loaded into the result register.
// A new request is taken only once the previous one's result has been loaded.
// Reset clears the used and held bitmaps; the memories need no clearing pass.
// A stalled result stops the block only when the next result is ready to load.
`default_nettype none
module owned_mutex_table #(
  parameter int unsigned SLOT_COUNT   = 64,
  parameter int unsigned PROC_ID_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [omt_pkg::IN_DATA_W-1:0]  in_tdata,  // opcode, slot_id, caller
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [omt_pkg::OUT_DATA_W-1:0] out_tdata  // status, granted_slot, pad
);

  omt_pkg::ctl_cmd_t cmd;
  omt_pkg::dp_stat_t stat;

  omt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  omt_dp #(
    .SLOT_COUNT   (SLOT_COUNT),
    .PROC_ID_BITS (PROC_ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign out_tvalid = stat.out_valid;

  // Only one request is in flight: the cycle after a transfer in takes no other.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a request is in flight");

  // Every commit follows a captured request.
  a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && $past(rst_n)) |-> ($past(cmd.capture) || $past(u_dp.out_valid_r)))
    else $error("commit without a captured request");

  // A new result appears only through a commit.
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  // Only a successful create reports a slot.
  a_granted_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] != omt_pkg::ST_OK)) |-> (out_tdata[8:3] == '0))
    else $error("granted slot on a failed request");

endmodule
`default_nettype wire

// ===== rtl/omt_ram.sv =====
`default_nettype none
module omt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/omt_ctrl.sv =====
`default_nettype none
module omt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              out_tready,
  input  wire omt_pkg::dp_stat_t stat,
  output omt_pkg::ctl_cmd_t      cmd
);

  omt_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= omt_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      omt_pkg::FSM_IDLE: begin
        // No transfer is taken while reset is held.
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = omt_pkg::FSM_EXEC;
        end
      end
      omt_pkg::FSM_EXEC: begin
        // The result register must be free, or be emptied in this cycle.
        if (!stat.out_valid || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = omt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = omt_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/omt_dp.sv =====
`default_nettype none
module omt_dp #(
  parameter int unsigned SLOT_COUNT   = 64,
  parameter int unsigned PROC_ID_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [omt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                               out_tready,
  output logic      [omt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire omt_pkg::ctl_cmd_t                  cmd,
  output omt_pkg::dp_stat_t                       stat
);

  localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
  localparam int unsigned CMP_W  =
    ((SLOT_W > omt_pkg::SLOT_ID_W) ? SLOT_W : omt_pkg::SLOT_ID_W) + 1;
  localparam int unsigned PAD_W  =
    omt_pkg::OUT_DATA_W - omt_pkg::STATUS_W - omt_pkg::GRANTED_W;

  // Request fields.
  omt_pkg::opcode_t                in_op;
  logic [omt_pkg::SLOT_ID_W-1:0]   in_slot;
  logic [omt_pkg::CALLER_W-1:0]    in_caller;
  logic [CMP_W-1:0]                slot_ext;

  assign in_op     = omt_pkg::opcode_t'(in_tdata[omt_pkg::OPCODE_W-1:0]);
  assign in_slot   = in_tdata[omt_pkg::OPCODE_W +: omt_pkg::SLOT_ID_W];
  assign in_caller = in_tdata[omt_pkg::OPCODE_W + omt_pkg::SLOT_ID_W +: omt_pkg::CALLER_W];
  assign slot_ext  = CMP_W'(in_slot);

  // A bit per slot: set while the slot is created, or while it is held.
  logic [SLOT_COUNT-1:0] created_r, created_nxt;
  logic [SLOT_COUNT-1:0] held_r, held_nxt;

  // Lowest free slot.
  logic [SLOT_W-1:0] free_idx;
  logic              any_free;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!created_r[i]) begin
        free_idx = SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  // Captured request.
  omt_pkg::opcode_t    op_r;
  logic [SLOT_W-1:0]   addr_r;
  logic                id_ok_r;
  logic                full_r;
  logic [PROC_ID_BITS-1:0] pid_r;
  logic [SLOT_W-1:0]   addr_sel;

  assign addr_sel = (in_op == omt_pkg::OP_CREATE) ? free_idx : SLOT_W'(slot_ext);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      addr_r  <= addr_sel;
      id_ok_r <= slot_ext < CMP_W'(SLOT_COUNT);
      full_r  <= !any_free;
      pid_r   <= PROC_ID_BITS'(in_caller);
    end
  end

  // Creator and holder stores; an entry only means something while its bit is set.
  logic                    c_we, h_we;
  logic [PROC_ID_BITS-1:0] c_rdata, h_rdata;

  omt_ram #(.WIDTH(PROC_ID_BITS), .DEPTH(SLOT_COUNT)) u_creator_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (addr_r),
    .wdata (pid_r),
    .re    (cmd.capture),
    .raddr (addr_sel),
    .rdata (c_rdata)
  );

  omt_ram #(.WIDTH(PROC_ID_BITS), .DEPTH(SLOT_COUNT)) u_holder_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (addr_r),
    .wdata (pid_r),
    .re    (cmd.capture),
    .raddr (addr_sel),
    .rdata (h_rdata)
  );

  logic                    pid_zero;
  logic                    is_creator;
  logic [PROC_ID_BITS-1:0] holder;
  omt_pkg::status_t        status;
  logic                    do_create, do_destroy, do_acquire, do_release;

  assign pid_zero   = (pid_r == '0);
  assign is_creator = created_r[addr_r] && (c_rdata == pid_r);
  assign holder     = held_r[addr_r] ? h_rdata : '0;

  always_comb begin
    status     = omt_pkg::ST_OK;
    do_create  = 1'b0;
    do_destroy = 1'b0;
    do_acquire = 1'b0;
    do_release = 1'b0;
    if (pid_zero) begin
      status = omt_pkg::ST_OWNER;
    end else if (op_r == omt_pkg::OP_CREATE) begin
      if (full_r) begin
        status = omt_pkg::ST_FULL;
      end else begin
        do_create = 1'b1;
      end
    end else if (!id_ok_r) begin
      status = omt_pkg::ST_INVALID;
    end else begin
      unique case (op_r)
        omt_pkg::OP_DESTROY: begin
          if (!is_creator) begin
            status = omt_pkg::ST_OWNER;
          end else begin
            do_destroy = 1'b1;
          end
        end
        omt_pkg::OP_ACQUIRE: begin
          if (holder == pid_r) begin
            status = omt_pkg::ST_OWNER;
          end else if (holder != '0) begin
            status = omt_pkg::ST_BUSY;
          end else begin
            do_acquire = 1'b1;
          end
        end
        omt_pkg::OP_RELEASE: begin
          if (holder != pid_r) begin
            status = omt_pkg::ST_OWNER;
          end else begin
            do_release = 1'b1;
          end
        end
        default: begin
          status = omt_pkg::ST_OK;
        end
      endcase
    end
  end

  assign c_we = cmd.commit && do_create;
  assign h_we = cmd.commit && do_acquire;

  always_comb begin
    created_nxt = created_r;
    held_nxt    = held_r;
    if (cmd.commit) begin
      if (do_create) begin
        created_nxt[addr_r] = 1'b1;
      end
      if (do_destroy) begin
        created_nxt[addr_r] = 1'b0;
        held_nxt[addr_r]    = 1'b0;
      end
      if (do_acquire) begin
        held_nxt[addr_r] = 1'b1;
      end
      if (do_release) begin
        held_nxt[addr_r] = 1'b0;
      end
    end
  end

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  omt_pkg::status_t              status_r;
  logic [omt_pkg::GRANTED_W-1:0] granted_r;

  assign out_valid_nxt = cmd.commit || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      created_r   <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      created_r   <= created_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status;
      granted_r <= do_create ? omt_pkg::GRANTED_W'(addr_r) : '0;
    end
  end

  assign stat.out_valid = out_valid_r;
  assign out_tdata      = {{PAD_W{1'b0}}, granted_r, status_r};

endmodule
`default_nettype wire
